@@ rtl/core/utf8l_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 filter package
// Transaction types, parser state and mode codes that the decoder and the
// top level share.
// ----------------------------------------------------------------------------
package utf8l_pkg;

   // Parser modes.
   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_BSLASH = 3'd1;
   localparam logic [2:0] MODE_ESC    = 3'd2;
   localparam logic [2:0] MODE_TWO    = 3'd3;
   localparam logic [2:0] MODE_SKIP   = 3'd4;

   // Most results that one input byte can cause.
   localparam int unsigned MAX_RESULTS = 5;
   // Bytes of an escape that are held after the 'u'.
   localparam int unsigned HELD_DEPTH  = 4;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;

   // Input transaction.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   // Parser state that reset clears.
   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  esc_count;
      logic [15:0] hex_value;
      logic        hex_stopped;
      logic [4:0]  lead_bits;
      logic [1:0]  skip_count;
   } state_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [2:0]                  count;
      logic                        no_byte;
      logic                        last;
   } group_type;

endpackage

@@ rtl/core/utf8_to_latin1_filter_top.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 filter, top level
// Byte stream filter that turns UTF-8 text with escapes into Latin-1 bytes.
// ----------------------------------------------------------------------------
// One input byte is accepted per clock while each causes at most one result
// and the output does not stall; a byte's results appear starting the cycle
// after it is accepted. A byte with more results (up to five, when an escape
// is cut short by the end of the string and replayed) holds the input until
// its last result is taken, as the result register hands out one result per
// unstalled cycle; the next byte is taken in the same cycle as that result.
module utf8_to_latin1_filter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  utf8l_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output utf8l_pkg::rsp_type rsp_data
);

   utf8l_pkg::state_type                    state_ff, state_in;
   logic [utf8l_pkg::HELD_DEPTH-1:0][7:0]   held_ff, held_in;
   utf8l_pkg::group_type                    grp_ff, grp_in;
   logic [2:0]                              idx_ff;
   logic                                    busy_ff;
   logic                                    take;
   logic                                    at_end;
   logic                                    accept;

   // Parser next-state logic.
   utf8l_decode u_decode (
      .req_data  (req_data),
      .state_cur (state_ff),
      .held_cur  (held_ff),
      .state_nxt (state_in),
      .held_nxt  (held_in),
      .group     (grp_in)
   );

   // Handshake: a new byte enters once the pending group is drained or drains now.
   assign take      = busy_ff && !rsp_stall;
   assign at_end    = (idx_ff == grp_ff.count - 3'd1);
   assign req_stall = busy_ff && !(take && at_end);
   assign accept    = req_valid && !req_stall;

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: utf8l_pkg::MODE_IDLE, default: '0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Held escape bytes need no reset; they are written before they are read.
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   // Result group register and its read pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (accept) begin
         busy_ff <= (grp_in.count != 3'd0);
         idx_ff  <= 3'd0;
      end else if (take) begin
         if (at_end) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff <= grp_in;
      end
   end

   // Present the current entry of the group.
   assign rsp_valid           = busy_ff;
   assign rsp_data.out_byte   = grp_ff.bytes[idx_ff];
   assign rsp_data.has_byte   = !grp_ff.no_byte;
   assign rsp_data.run_last   = at_end;
   assign rsp_data.stream_end = at_end && grp_ff.last;

   // The read pointer stays inside the loaded group.
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < grp_ff.count))
      else $error("result pointer beyond group");

   // The empty end marker is a group of exactly one result that ends the string.
   a_marker_alone: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && grp_ff.no_byte) |-> (grp_ff.count == 3'd1 && grp_ff.last))
      else $error("empty marker in a larger group");

   // While the results of a final byte drain, the parser is back at idle.
   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && grp_ff.last) |->
         (state_ff.mode == utf8l_pkg::MODE_IDLE && state_ff.esc_count == 2'd0))
      else $error("parser not idle after end of string");

   // The escape counter only runs inside an escape.
   a_count_in_escape: assert property (@(posedge clock) disable iff (reset)
      (state_ff.esc_count != 2'd0) |-> (state_ff.mode == utf8l_pkg::MODE_ESC))
      else $error("escape count outside an escape");

endmodule

@@ rtl/core/utf8l_decode.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to Latin-1 byte decoder
// Combinational next-state logic: takes the parser state and one input byte
// and produces the next state and the group of result bytes for that input.
// ----------------------------------------------------------------------------
module utf8l_decode (
   input  utf8l_pkg::req_type                          req_data,
   input  utf8l_pkg::state_type                        state_cur,
   input  logic [utf8l_pkg::HELD_DEPTH-1:0][7:0]       held_cur,
   output utf8l_pkg::state_type                        state_nxt,
   output logic [utf8l_pkg::HELD_DEPTH-1:0][7:0]       held_nxt,
   output utf8l_pkg::group_type                        group
);

   // Hex digit value, with a flag for a valid digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   always_comb begin
      logic [2:0] n;
      logic [7:0] b;
      logic       do_start;
      logic [4:0] dig;
      logic [1:0] rp_skip;
      logic [7:0] c;
      logic [7:0] c_next;

      b         = req_data.in_byte;
      n         = 3'd0;
      do_start  = 1'b0;
      dig       = hex_digit(b);
      rp_skip   = 2'd0;
      c         = 8'd0;
      c_next    = 8'd0;
      state_nxt = state_cur;
      held_nxt  = held_cur;
      group     = '0;

      // Main parse step for the current mode.
      unique case (state_cur.mode)
         utf8l_pkg::MODE_BSLASH: begin
            if (b == utf8l_pkg::CHAR_U) begin
               state_nxt.mode        = utf8l_pkg::MODE_ESC;
               state_nxt.esc_count   = 2'd0;
               state_nxt.hex_value   = 16'd0;
               state_nxt.hex_stopped = 1'b0;
            end else begin
               group.bytes[n] = utf8l_pkg::CHAR_BSLASH;
               n = n + 3'd1;
               do_start = 1'b1;
            end
         end
         utf8l_pkg::MODE_ESC: begin
            held_nxt[state_cur.esc_count] = b;
            if (state_cur.hex_stopped || !dig[4]) begin
               state_nxt.hex_stopped = 1'b1;
            end else begin
               state_nxt.hex_value = {state_cur.hex_value[11:0], dig[3:0]};
            end
            state_nxt.esc_count = state_cur.esc_count + 2'd1;
            if (state_cur.esc_count == 2'd3) begin
               // Fourth byte after the 'u' closes the escape.
               if (state_nxt.hex_value[15:7] == 9'd0) begin
                  group.bytes[n] = state_nxt.hex_value[7:0];
                  n = n + 3'd1;
               end
               state_nxt.mode = utf8l_pkg::MODE_IDLE;
            end
         end
         utf8l_pkg::MODE_TWO: begin
            if (state_cur.lead_bits[4:2] == 3'd0) begin
               group.bytes[n] = {state_cur.lead_bits[1:0], b[5:0]};
               n = n + 3'd1;
            end
            state_nxt.mode = utf8l_pkg::MODE_IDLE;
         end
         utf8l_pkg::MODE_SKIP: begin
            if (state_cur.skip_count != 2'd0) begin
               state_nxt.skip_count = state_cur.skip_count - 2'd1;
            end
            if (state_nxt.skip_count == 2'd0) begin
               state_nxt.mode = utf8l_pkg::MODE_IDLE;
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase

      // Classify a byte that starts a new character.
      if (do_start) begin
         state_nxt.mode = utf8l_pkg::MODE_IDLE;
         if (!b[7]) begin
            if (b == utf8l_pkg::CHAR_BSLASH) begin
               state_nxt.mode = utf8l_pkg::MODE_BSLASH;
            end else begin
               group.bytes[n] = b;
               n = n + 3'd1;
            end
         end else if ((b & 8'hE0) == 8'hC0) begin
            state_nxt.lead_bits = b[4:0];
            state_nxt.mode      = utf8l_pkg::MODE_TWO;
         end else if ((b & 8'hF0) == 8'hE0) begin
            state_nxt.skip_count = 2'd2;
            state_nxt.mode       = utf8l_pkg::MODE_SKIP;
         end else if ((b & 8'hF8) == 8'hF0) begin
            state_nxt.skip_count = 2'd3;
            state_nxt.mode       = utf8l_pkg::MODE_SKIP;
         end
      end

      // End of string: flush a pending backslash or replay a cut escape.
      if (req_data.is_last) begin
         if (state_nxt.mode == utf8l_pkg::MODE_BSLASH) begin
            group.bytes[n] = utf8l_pkg::CHAR_BSLASH;
            n = n + 3'd1;
         end else if (state_nxt.mode == utf8l_pkg::MODE_ESC) begin
            group.bytes[n] = utf8l_pkg::CHAR_BSLASH;
            n = n + 3'd1;
            group.bytes[n] = utf8l_pkg::CHAR_U;
            n = n + 3'd1;
            // Held bytes are decoded as plain text; no escape forms in them.
            for (int j = 0; j < 3; j++) begin
               c      = held_nxt[j];
               c_next = held_nxt[j+1];
               if (rp_skip != 2'd0) begin
                  rp_skip = rp_skip - 2'd1;
               end else if (2'(j) < state_nxt.esc_count) begin
                  if (!c[7]) begin
                     group.bytes[n] = c;
                     n = n + 3'd1;
                  end else if ((c & 8'hE0) == 8'hC0) begin
                     if (2'(j + 1) < state_nxt.esc_count && c[4:2] == 3'd0) begin
                        group.bytes[n] = {c[1:0], c_next[5:0]};
                        n = n + 3'd1;
                     end
                     rp_skip = 2'd1;
                  end else if ((c & 8'hF0) == 8'hE0) begin
                     rp_skip = 2'd2;
                  end else if ((c & 8'hF8) == 8'hF0) begin
                     rp_skip = 2'd3;
                  end
               end
            end
         end
         state_nxt.mode        = utf8l_pkg::MODE_IDLE;
         state_nxt.esc_count   = 2'd0;
         state_nxt.skip_count  = 2'd0;
         state_nxt.hex_value   = 16'd0;
         state_nxt.hex_stopped = 1'b0;
         // A string that ends with nothing emitted still gives one marker.
         if (n == 3'd0) begin
            group.no_byte = 1'b1;
            n = 3'd1;
         end
      end

      group.count = n;
      group.last  = req_data.is_last;
   end

endmodule
